/* rtl/fwd_pkg.sv */
// Package for the FIFO with delete by identifier.
// Holds default sizes, command and status codes, cell operations and sequencer states.
// No dependencies.
`default_nettype none

package fwd_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int ID_BITS_DEF   = 16;
   localparam int TIME_BITS_DEF = 16;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_SERVE  = 2'd1,
      CMD_LIST   = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_ADDED     = 3'd0,
      STAT_SERVED    = 3'd1,
      STAT_LISTED    = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_DELETED   = 3'd4,
      STAT_NOT_FOUND = 3'd5,
      STAT_FULL      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_SHIFT  = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LIST   = 2'd1,
      ST_DELETE = 2'd2
   } state_type;

endpackage

`default_nettype wire

/* rtl/fwd_req_if.sv */
// Request channel: command word with valid/ready.
// Depends on nothing; widths set by parameters.
`default_nettype none

interface fwd_req_if #(
   parameter int ID_BITS   = 16,
   parameter int TIME_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [TIME_BITS-1:0] service_minutes;
   logic [ID_BITS-1:0]   target_id;

   modport source (output valid, cmd, service_minutes, target_id, input ready);
   modport sink   (input valid, cmd, service_minutes, target_id, output ready);
endinterface

`default_nettype wire

/* rtl/fwd_rsp_if.sv */
// Response channel: result word with valid/ready.
// Depends on nothing; widths set by parameters.
`default_nettype none

interface fwd_rsp_if #(
   parameter int ID_BITS   = 16,
   parameter int TIME_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [ID_BITS-1:0]   entry_id;
   logic [TIME_BITS-1:0] entry_minutes;
   logic                 last;

   modport source (output valid, status, entry_id, entry_minutes, last, input ready);
   modport sink   (input valid, status, entry_id, entry_minutes, last, output ready);
endinterface

`default_nettype wire

/* rtl/fifo_with_delete_by_id_top.sv */
// Add and serve: result word registered the cycle after acceptance.
// Full, empty and not-found answers: likewise registered the cycle after acceptance.
// List of n entries: one word and chain rotation per cycle after acceptance, unless stalled.
// Delete with a match among n entries: one chain step per entry; removals wait on output stalls.
// Commands taken once a pass is done and the output is free; up to one command per cycle.
// Synchronous reset clears cell valid bits, occupancy and sets the identifier counter to one.
`default_nettype none

module fifo_with_delete_by_id_top #(
   parameter int DEPTH     = fwd_pkg::DEPTH_DEF,
   parameter int ID_BITS   = fwd_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = fwd_pkg::TIME_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   fwd_req_if.sink   req_ch,
   fwd_rsp_if.source rsp_ch
);

   fwd_pkg::cell_op_type cell_op;
   logic [ID_BITS-1:0]   target_id;
   logic [ID_BITS-1:0]   new_id;
   logic [TIME_BITS-1:0] new_minutes;

   logic [DEPTH-1:0]     valid_w;
   logic [DEPTH-1:0]     match_w;
   logic [ID_BITS-1:0]   id_w  [DEPTH];
   logic [TIME_BITS-1:0] min_w [DEPTH];

   fwd_ctrl #(
      .DEPTH     (DEPTH),
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .head_valid   (valid_w[0]),
      .tail_valid   (valid_w[DEPTH-1]),
      .head_id      (id_w[0]),
      .head_minutes (min_w[0]),
      .match_vec    (match_w),
      .cell_op      (cell_op),
      .target_id    (target_id),
      .new_id       (new_id),
      .new_minutes  (new_minutes)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 prev_valid;
      logic                 next_valid;
      logic [ID_BITS-1:0]   next_id;
      logic [TIME_BITS-1:0] next_minutes;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_prev
         assign prev_valid = valid_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_valid   = 1'b0;
         assign next_id      = '0;
         assign next_minutes = '0;
      end else begin : g_next
         assign next_valid   = valid_w[i+1];
         assign next_id      = id_w[i+1];
         assign next_minutes = min_w[i+1];
      end

      fwd_cell #(
         .ID_BITS   (ID_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (cell_op),
         .new_id       (new_id),
         .new_minutes  (new_minutes),
         .target_id    (target_id),
         .prev_valid   (prev_valid),
         .next_valid   (next_valid),
         .next_id      (next_id),
         .next_minutes (next_minutes),
         .head_id      (id_w[0]),
         .head_minutes (min_w[0]),
         .valid        (valid_w[i]),
         .id           (id_w[i]),
         .minutes      (min_w[i]),
         .match        (match_w[i])
      );
   end

endmodule

`default_nettype wire

/* rtl/fwd_cell.sv */
// One storage cell of the entry chain: identifier, service time, valid bit.
// Depends on fwd_pkg (cell operations).
`default_nettype none

module fwd_cell #(
   parameter int ID_BITS   = fwd_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = fwd_pkg::TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fwd_pkg::cell_op_type  op,
   input  wire logic [ID_BITS-1:0]    new_id,
   input  wire logic [TIME_BITS-1:0]  new_minutes,
   input  wire logic [ID_BITS-1:0]    target_id,
   input  wire logic                  prev_valid,
   input  wire logic                  next_valid,
   input  wire logic [ID_BITS-1:0]    next_id,
   input  wire logic [TIME_BITS-1:0]  next_minutes,
   input  wire logic [ID_BITS-1:0]    head_id,
   input  wire logic [TIME_BITS-1:0]  head_minutes,
   output logic                       valid,
   output logic [ID_BITS-1:0]         id,
   output logic [TIME_BITS-1:0]       minutes,
   output logic                       match
);

   logic                 valid_ff, valid_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] minutes_ff, minutes_in;

   always_comb begin
      valid_in   = valid_ff;
      id_in      = id_ff;
      minutes_in = minutes_ff;
      case (op)
         fwd_pkg::OP_LOAD: begin
            if (!valid_ff && prev_valid) begin
               valid_in   = 1'b1;
               id_in      = new_id;
               minutes_in = new_minutes;
            end
         end
         fwd_pkg::OP_SHIFT: begin
            valid_in   = next_valid;
            id_in      = next_id;
            minutes_in = next_minutes;
         end
         fwd_pkg::OP_ROTATE: begin
            // last valid cell takes the head word, the valid cells before it move up
            if (next_valid) begin
               id_in      = next_id;
               minutes_in = next_minutes;
            end else if (valid_ff) begin
               id_in      = head_id;
               minutes_in = head_minutes;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      minutes_ff <= minutes_in;
   end

   assign valid   = valid_ff;
   assign id      = id_ff;
   assign minutes = minutes_ff;
   assign match   = valid_ff && (id_ff == target_id);

endmodule

`default_nettype wire

/* rtl/fwd_ctrl.sv */
// Sequencer and result register: decodes commands, drives the cell chain, steps list and delete
// passes one entry per cycle unless a result word is held up. Depends on fwd_pkg, fwd_req_if, fwd_rsp_if.
`default_nettype none

module fwd_ctrl #(
   parameter int DEPTH     = fwd_pkg::DEPTH_DEF,
   parameter int ID_BITS   = fwd_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = fwd_pkg::TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fwd_req_if.sink                   req_ch,
   fwd_rsp_if.source                 rsp_ch,
   input  wire logic                 head_valid,
   input  wire logic                 tail_valid,
   input  wire logic [ID_BITS-1:0]   head_id,
   input  wire logic [TIME_BITS-1:0] head_minutes,
   input  wire logic [DEPTH-1:0]     match_vec,
   output fwd_pkg::cell_op_type      cell_op,
   output logic [ID_BITS-1:0]        target_id,
   output logic [ID_BITS-1:0]        new_id,
   output logic [TIME_BITS-1:0]      new_minutes
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   fwd_pkg::state_type   state_ff, state_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [OCC_W-1:0]     step_ff, step_in;
   logic [ID_BITS-1:0]   ctr_ff, ctr_in;
   logic [ID_BITS-1:0]   target_ff, target_in;

   logic                 rsp_valid_ff;
   fwd_pkg::status_type  status_ff;
   logic [ID_BITS-1:0]   eid_ff;
   logic [TIME_BITS-1:0] emin_ff;
   logic                 elast_ff;

   logic                 out_free;
   logic                 emit;
   fwd_pkg::status_type  e_status;
   logic [ID_BITS-1:0]   e_id;
   logic [TIME_BITS-1:0] e_min;
   logic                 e_last;
   logic                 more_matches;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign more_matches = |match_vec[DEPTH-1:1];

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      step_in      = step_ff;
      ctr_in       = ctr_ff;
      target_in    = target_ff;
      cell_op      = fwd_pkg::OP_HOLD;
      emit         = 1'b0;
      e_status     = fwd_pkg::STAT_EMPTY;
      e_id         = '0;
      e_min        = '0;
      e_last       = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         fwd_pkg::ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               case (fwd_pkg::cmd_type'(req_ch.cmd))
                  fwd_pkg::CMD_ADD: begin
                     emit   = 1'b1;
                     e_last = 1'b1;
                     if (tail_valid) begin
                        e_status = fwd_pkg::STAT_FULL;
                     end else begin
                        cell_op  = fwd_pkg::OP_LOAD;
                        e_status = fwd_pkg::STAT_ADDED;
                        e_id     = ctr_ff;
                        occ_in   = occ_ff + OCC_W'(1);
                        ctr_in   = (&ctr_ff) ? ID_BITS'(1) : ctr_ff + ID_BITS'(1);
                     end
                  end
                  fwd_pkg::CMD_SERVE: begin
                     emit   = 1'b1;
                     e_last = 1'b1;
                     if (head_valid) begin
                        cell_op  = fwd_pkg::OP_SHIFT;
                        e_status = fwd_pkg::STAT_SERVED;
                        e_id     = head_id;
                        e_min    = head_minutes;
                        occ_in   = occ_ff - OCC_W'(1);
                     end
                  end
                  fwd_pkg::CMD_LIST: begin
                     if (head_valid) begin
                        step_in  = occ_ff;
                        state_in = fwd_pkg::ST_LIST;
                     end else begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                     end
                  end
                  fwd_pkg::CMD_DELETE: begin
                     if (|match_vec) begin
                        target_in = req_ch.target_id;
                        step_in   = occ_ff;
                        state_in  = fwd_pkg::ST_DELETE;
                     end else begin
                        emit     = 1'b1;
                        e_last   = 1'b1;
                        e_status = fwd_pkg::STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         fwd_pkg::ST_LIST: begin
            if (out_free) begin
               cell_op  = fwd_pkg::OP_ROTATE;
               emit     = 1'b1;
               e_status = fwd_pkg::STAT_LISTED;
               e_id     = head_id;
               e_min    = head_minutes;
               e_last   = (step_ff == OCC_W'(1));
               step_in  = step_ff - OCC_W'(1);
               if (e_last) begin
                  state_in = fwd_pkg::ST_IDLE;
               end
            end
         end
         fwd_pkg::ST_DELETE: begin
            // head is always the next unvisited entry: drop it or send it to the tail
            if (match_vec[0]) begin
               if (out_free) begin
                  cell_op  = fwd_pkg::OP_SHIFT;
                  emit     = 1'b1;
                  e_status = fwd_pkg::STAT_DELETED;
                  e_id     = head_id;
                  e_min    = head_minutes;
                  e_last   = !more_matches;
                  occ_in   = occ_ff - OCC_W'(1);
                  step_in  = step_ff - OCC_W'(1);
                  if (step_ff == OCC_W'(1)) begin
                     state_in = fwd_pkg::ST_IDLE;
                  end
               end
            end else begin
               cell_op = fwd_pkg::OP_ROTATE;
               step_in = step_ff - OCC_W'(1);
               if (step_ff == OCC_W'(1)) begin
                  state_in = fwd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = fwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwd_pkg::ST_IDLE;
         occ_ff       <= '0;
         step_ff      <= '0;
         ctr_ff       <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         step_ff  <= step_in;
         ctr_ff   <= ctr_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      if (emit) begin
         status_ff <= e_status;
         eid_ff    <= e_id;
         emin_ff   <= e_min;
         elast_ff  <= e_last;
      end
   end

   assign target_id   = (state_ff == fwd_pkg::ST_IDLE) ? req_ch.target_id : target_ff;
   assign new_id      = ctr_ff;
   assign new_minutes = req_ch.service_minutes;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.entry_id      = eid_ff;
   assign rsp_ch.entry_minutes = emin_ff;
   assign rsp_ch.last          = elast_ff;

`ifndef NO_ASSERTIONS
   a_occ_empty: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) == !head_valid)
      else $error("occupancy disagrees with head valid bit");

   a_occ_full: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == OCC_W'(DEPTH)) == tail_valid)
      else $error("occupancy disagrees with tail valid bit");

   a_list_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fwd_pkg::ST_LIST) |-> (step_ff != '0) && (step_ff <= occ_ff))
      else $error("list pass step count out of range");

   a_del_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fwd_pkg::ST_DELETE) |-> (step_ff != '0) && (step_ff <= occ_ff))
      else $error("delete pass step count out of range");
`endif

endmodule

`default_nettype wire

/* test/fifo_with_delete_by_id_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for the FIFO with delete by identifier: directed and random commands,
// every result word checked against a behavioural copy of the store kept here.
// Depends on fwd_pkg, fwd_req_if, fwd_rsp_if and fifo_with_delete_by_id_top.

module fifo_with_delete_by_id_top_tb;

   localparam int DEPTH        = fwd_pkg::DEPTH_DEF;
   localparam int ID_W         = fwd_pkg::ID_BITS_DEF;
   localparam int TIME_W       = fwd_pkg::TIME_BITS_DEF;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 80;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      fwd_pkg::status_type st;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   mins;
      logic                last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fwd_req_if #(.ID_BITS(ID_W), .TIME_BITS(TIME_W)) req_ch ();
   fwd_rsp_if #(.ID_BITS(ID_W), .TIME_BITS(TIME_W)) rsp_ch ();

   fifo_with_delete_by_id_top #(
      .DEPTH(DEPTH),
      .ID_BITS(ID_W),
      .TIME_BITS(TIME_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // shadow store, head at cell 0
   logic [ID_W-1:0]   cell_id  [DEPTH];
   logic [TIME_W-1:0] cell_min [DEPTH];
   int                fill = 0;
   logic [ID_W-1:0]   id_counter = ID_W'(1);
   rsp_word_type      pending_words [$];

   int  errors, n_results, id_wraps, n_full, n_empty, n_not_found, n_deleted;
   int  cmd_count [4];
   int  quiet_cycles;
   bit  idle_on;
   bit  hold_req;
   bit  hold_ack;

   function automatic void queue_word(fwd_pkg::status_type st, logic [ID_W-1:0] id,
                                      logic [TIME_W-1:0] m, logic last);
      rsp_word_type w;
      w.st   = st;
      w.id   = id;
      w.mins = m;
      w.last = last;
      pending_words = {pending_words, w};
   endfunction

   function automatic void apply_command(fwd_pkg::cmd_type c, logic [TIME_W-1:0] m,
                                         logic [ID_W-1:0] t);
      int k, w, hits, seen;
      cmd_count[int'(c)]++;
      case (c)
         fwd_pkg::CMD_ADD: begin
            if (fill >= DEPTH) begin
               queue_word(fwd_pkg::STAT_FULL, '0, '0, 1'b1);
               n_full++;
            end else begin
               cell_id[fill]  = id_counter;
               cell_min[fill] = m;
               fill++;
               queue_word(fwd_pkg::STAT_ADDED, id_counter, '0, 1'b1);
               if (id_counter == '1) begin
                  id_counter = ID_W'(1);
                  id_wraps++;
               end else begin
                  id_counter = id_counter + 1'b1;
               end
            end
         end
         fwd_pkg::CMD_SERVE: begin
            if (fill == 0) begin
               queue_word(fwd_pkg::STAT_EMPTY, '0, '0, 1'b1);
               n_empty++;
            end else begin
               queue_word(fwd_pkg::STAT_SERVED, cell_id[0], cell_min[0], 1'b1);
               for (k = 1; k < fill; k++) begin
                  cell_id[k-1]  = cell_id[k];
                  cell_min[k-1] = cell_min[k];
               end
               fill--;
            end
         end
         fwd_pkg::CMD_LIST: begin
            if (fill == 0) begin
               queue_word(fwd_pkg::STAT_EMPTY, '0, '0, 1'b1);
               n_empty++;
            end else begin
               for (k = 0; k < fill; k++)
                  queue_word(fwd_pkg::STAT_LISTED, cell_id[k], cell_min[k], k == fill - 1);
            end
         end
         fwd_pkg::CMD_DELETE: begin
            hits = 0;
            for (k = 0; k < fill; k++)
               if (cell_id[k] == t) hits++;
            w    = 0;
            seen = 0;
            for (k = 0; k < fill; k++) begin
               if (cell_id[k] == t) begin
                  seen++;
                  queue_word(fwd_pkg::STAT_DELETED, cell_id[k], cell_min[k], seen == hits);
                  n_deleted++;
               end else begin
                  cell_id[w]  = cell_id[k];
                  cell_min[w] = cell_min[k];
                  w++;
               end
            end
            fill = w;
            if (hits == 0) begin
               queue_word(fwd_pkg::STAT_NOT_FOUND, '0, '0, 1'b1);
               n_not_found++;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void note_mismatch(string why, rsp_word_type want, rsp_word_type got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display({"%0t: %s: expected status %0d id %0d minutes %0d last %0b, ",
                   "got status %0d id %0d minutes %0d last %0b"},
                  $time, why, want.st, want.id, want.mins, want.last,
                  got.st, got.id, got.mins, got.last);
   endfunction

   // prediction on each accepted command word
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         apply_command(fwd_pkg::cmd_type'(req_ch.cmd), req_ch.service_minutes,
                       req_ch.target_id);
   end

   always @(posedge clock) begin : check_results
      rsp_word_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         got.st   = fwd_pkg::status_type'(rsp_ch.status);
         got.id   = rsp_ch.entry_id;
         got.mins = rsp_ch.entry_minutes;
         got.last = rsp_ch.last;
         if (pending_words.size() == 0) begin
            want = '0;
            note_mismatch("unexpected result word", want, got);
         end else begin
            want = pending_words.pop_front();
            if (got !== want)
               note_mismatch("result word mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_words.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
            hold_ack = hold_req;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(fwd_pkg::cmd_type c, logic [TIME_W-1:0] m, logic [ID_W-1:0] t);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.cmd             <= c;
      req_ch.service_minutes <= m;
      req_ch.target_id       <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_store();
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      send_word(fwd_pkg::CMD_LIST, '1, '1);
      send_word(fwd_pkg::CMD_DELETE, '0, '0);
      send_word(fwd_pkg::CMD_DELETE, '1, '1);
      stop_sending();
   endtask

   // ids are 1, 2, 3 straight after reset
   task automatic test_basic_ops();
      send_word(fwd_pkg::CMD_ADD, '0, '1);
      send_word(fwd_pkg::CMD_ADD, '1, '0);
      send_word(fwd_pkg::CMD_ADD, 16'hA5A5, 16'h5A5A);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      send_word(fwd_pkg::CMD_DELETE, '0, 16'd2);
      send_word(fwd_pkg::CMD_DELETE, '0, 16'd2);
      send_word(fwd_pkg::CMD_DELETE, '1, '0);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      stop_sending();
   endtask

   task automatic test_fill_to_full();
      int i;
      for (i = 0; i < DEPTH + 2; i++)
         send_word(fwd_pkg::CMD_ADD, TIME_W'($urandom), ID_W'($urandom));
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      send_word(fwd_pkg::CMD_DELETE, '0, cell_id[DEPTH/2]);
      send_word(fwd_pkg::CMD_ADD, TIME_W'($urandom), '0);
      send_word(fwd_pkg::CMD_ADD, TIME_W'($urandom), '0);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      stop_sending();
   endtask

   task automatic test_backpressure();
      int i;
      hold_req = !hold_req;
      for (i = 0; i < 30; i++) begin
         if (i % 7 == 6)
            send_word(fwd_pkg::CMD_LIST, '0, '0);
         else if (i % 5 == 4)
            send_word(fwd_pkg::CMD_SERVE, '0, '0);
         else
            send_word(fwd_pkg::CMD_ADD, TIME_W'($urandom), '0);
      end
      stop_sending();
   endtask

   task automatic test_random_mix(int n_items);
      int i, pick;
      bit filling;
      fwd_pkg::cmd_type c;
      logic [ID_W-1:0] t;
      filling = 1'b1;
      for (i = 0; i < n_items; i++) begin
         if (i % 40 == 0) filling = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 55 : 20))      c = fwd_pkg::CMD_ADD;
         else if (pick < (filling ? 70 : 60)) c = fwd_pkg::CMD_SERVE;
         else if (pick < (filling ? 80 : 72)) c = fwd_pkg::CMD_LIST;
         else                                 c = fwd_pkg::CMD_DELETE;
         pick = $urandom_range(0, 99);
         if (pick < 60 && fill > 0) t = cell_id[$urandom_range(0, fill - 1)];
         else if (pick < 70)        t = '0;
         else if (pick < 80)        t = id_counter;
         else                       t = ID_W'($urandom);
         send_word(c, TIME_W'($urandom), t);
      end
      stop_sending();
   endtask

   // two serves, ten adds, a list, deletes of the top identifier, of one and of it again, a list
   task automatic test_refill_and_delete();
      int i;
      wait_for_results();
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      send_word(fwd_pkg::CMD_SERVE, '0, '0);
      for (i = 0; i < 10; i++)
         send_word(fwd_pkg::CMD_ADD, TIME_W'($urandom), '0);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      send_word(fwd_pkg::CMD_DELETE, '0, '1);
      send_word(fwd_pkg::CMD_DELETE, '0, 16'd1);
      send_word(fwd_pkg::CMD_DELETE, '0, '1);
      send_word(fwd_pkg::CMD_LIST, '0, '0);
      stop_sending();
   endtask

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.cmd             = fwd_pkg::CMD_ADD;
      req_ch.service_minutes = '0;
      req_ch.target_id       = '0;
      idle_on    = 1'b1;
      hold_req   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_basic_ops();
      test_fill_to_full();
      test_backpressure();
      test_random_mix(270);
      idle_on = 1'b0;
      test_refill_and_delete();
      test_random_mix(80);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Commands: %0d add, %0d serve, %0d list, %0d delete; %0d result words checked",
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], n_results);
      $display({"Answers: %0d full, %0d empty, %0d not found, %0d removed; ",
                "%0d counter wraps; %0d mismatches"},
               n_full, n_empty, n_not_found, n_deleted, id_wraps, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/fwd_pkg.sv
rtl/fwd_req_if.sv
rtl/fwd_rsp_if.sv
rtl/fwd_cell.sv
rtl/fwd_ctrl.sv
rtl/fifo_with_delete_by_id_top.sv
test/fifo_with_delete_by_id_top_tb.sv
